// File: rtl/core/ia32ml_pkg.sv
// Shared types and constants for the IA-32 move/lea decoder.
`default_nettype none

package ia32ml_pkg;

   // Opcode bytes of the supported subset
   localparam logic [7:0] OP_NOP      = 8'h90;
   localparam logic [7:0] OP_MOVI_LO  = 8'hb8;
   localparam logic [7:0] OP_MOVI_HI  = 8'hbf;
   localparam logic [7:0] OP_MOV_STORE = 8'h89;
   localparam logic [7:0] OP_MOV_LOAD = 8'h8b;
   localparam logic [7:0] OP_LEA      = 8'h8d;

   // ModRM / SIB special codes
   localparam logic [1:0] MOD_NODISP  = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP32  = 2'd2;
   localparam logic [1:0] MOD_REG     = 2'd3;
   localparam logic [2:0] RM_SIB      = 3'd4;
   localparam logic [2:0] RM_DISP32   = 3'd5;
   localparam logic [2:0] SIB_NO_INDEX = 3'd4;
   localparam logic [2:0] SIB_NO_BASE = 3'd5;

   // Immediate and displacement sizes in bytes
   localparam logic [2:0] IMM32_BYTES = 3'd4;
   localparam logic [2:0] DISP8_BYTES = 3'd1;
   localparam logic [2:0] DISP32_BYTES = 3'd4;
   localparam logic [2:0] NO_BYTES    = 3'd0;

   typedef enum logic [1:0] {
      KIND_NOP  = 2'd0,
      KIND_MOVI = 2'd1,
      KIND_MOVR = 2'd2,
      KIND_LEA  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_MODRM  = 2'd1,
      PH_SIB    = 2'd2,
      PH_VALUE  = 2'd3
   } phase_type;

   typedef enum logic {
      ST_OK     = 1'b0,
      ST_REJECT = 1'b1
   } status_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       abandon;
   } req_type;

   typedef struct packed {
      status_type  status;
      kind_type    kind;
      logic [2:0]  dst_reg;
      logic [2:0]  src_reg;
      logic        has_base;
      logic [2:0]  base_num;
      logic        has_index;
      logic [2:0]  index_num;
      logic [1:0]  scale_shift;
      logic [31:0] value;
      logic [2:0]  length;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/ia32ml_decode.sv
// Byte-serial decode state and per-byte decode logic.
`default_nettype none

module ia32ml_decode
   import ia32ml_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    beat_accept,
   input  wire req_type req_data,
   output logic         res_valid,
   output rsp_type      res_data
);

   phase_type   phase_ff, phase_in, cur_phase;
   kind_type    kind_ff, kind_in;
   logic        dir_ff, dir_in;
   logic [1:0]  mod_ff, mod_in;
   logic [2:0]  reg_ff, reg_in;
   logic [2:0]  rm_ff, rm_in;
   logic [7:0]  sib_ff, sib_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  b;

   // Displacement size for the addressing form
   function automatic logic [2:0] disp_bytes(input logic [1:0] md, input logic [2:0] rm,
                                             input logic [7:0] sib);
      logic [2:0] n;
      n = NO_BYTES;
      if (md == MOD_DISP8) n = DISP8_BYTES;
      else if (md == MOD_DISP32) n = DISP32_BYTES;
      else if (rm == RM_DISP32) n = DISP32_BYTES;
      else if (rm == RM_SIB && sib[2:0] == SIB_NO_BASE) n = DISP32_BYTES;
      return n;
   endfunction

   // Build a finished lea result
   function automatic rsp_type lea_result(input logic [1:0] md, input logic [2:0] rm,
                                          input logic [7:0] sib, input logic [2:0] rg,
                                          input logic [31:0] val, input logic [2:0] len);
      rsp_type r;
      r = '0;
      r.status = ST_OK;
      r.kind   = KIND_LEA;
      r.dst_reg = rg;
      r.value  = val;
      r.length = len;
      if (rm == RM_SIB) begin
         r.scale_shift = sib[7:6];
         if (sib[5:3] != SIB_NO_INDEX) begin
            r.has_index = 1'b1;
            r.index_num = sib[5:3];
         end
         r.has_base = !(md == MOD_NODISP && sib[2:0] == SIB_NO_BASE);
         if (r.has_base) r.base_num = sib[2:0];
      end else begin
         r.has_base = !(md == MOD_NODISP && rm == RM_DISP32);
         if (r.has_base) r.base_num = rm;
      end
      return r;
   endfunction

   // Rejection result carries only the reject status and the length
   function automatic rsp_type reject_result(input logic [2:0] len);
      rsp_type r;
      r = '0;
      r.status = ST_REJECT;
      r.kind   = KIND_NOP;
      r.length = len;
      return r;
   endfunction

   assign b = req_data.code_byte;
   assign cur_phase = req_data.abandon ? PH_OPCODE : phase_ff;

   // Decode one byte against the held state
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      dir_in    = dir_ff;
      mod_in    = mod_ff;
      reg_in    = reg_ff;
      rm_in     = rm_ff;
      sib_in    = sib_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      cnt_in    = cnt_ff;
      res_valid = 1'b0;
      res_data  = '0;
      if (beat_accept) begin
         case (cur_phase)
            PH_MODRM: begin
               cnt_in = cnt_ff + 3'd1;
               mod_in = b[7:6];
               reg_in = b[5:3];
               rm_in  = b[2:0];
               if (kind_ff == KIND_MOVR) begin
                  res_valid = 1'b1;
                  phase_in  = PH_OPCODE;
                  if (mod_in != MOD_REG) begin
                     res_data = reject_result(cnt_in);
                  end else begin
                     res_data.status  = ST_OK;
                     res_data.kind    = KIND_MOVR;
                     res_data.dst_reg = dir_ff ? reg_in : rm_in;
                     res_data.src_reg = dir_ff ? rm_in : reg_in;
                     res_data.length  = cnt_in;
                  end
               end else if (mod_in == MOD_REG) begin
                  res_valid = 1'b1;
                  phase_in  = PH_OPCODE;
                  res_data  = reject_result(cnt_in);
               end else if (rm_in == RM_SIB) begin
                  phase_in = PH_SIB;
               end else begin
                  sib_in = '0;
                  acc_in = '0;
                  if (disp_bytes(mod_in, rm_in, sib_in) == NO_BYTES) begin
                     res_valid = 1'b1;
                     phase_in  = PH_OPCODE;
                     res_data  = lea_result(mod_in, rm_in, sib_in, reg_in, acc_in, cnt_in);
                  end else begin
                     pend_in  = disp_bytes(mod_in, rm_in, sib_in);
                     phase_in = PH_VALUE;
                  end
               end
            end
            PH_SIB: begin
               cnt_in = cnt_ff + 3'd1;
               sib_in = b;
               acc_in = '0;
               if (disp_bytes(mod_ff, rm_ff, sib_in) == NO_BYTES) begin
                  res_valid = 1'b1;
                  phase_in  = PH_OPCODE;
                  res_data  = lea_result(mod_ff, rm_ff, sib_in, reg_ff, acc_in, cnt_in);
               end else begin
                  pend_in  = disp_bytes(mod_ff, rm_ff, sib_in);
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               cnt_in = cnt_ff + 3'd1;
               if (kind_ff == KIND_LEA && mod_ff == MOD_DISP8) acc_in = {{24{b[7]}}, b};
               else acc_in = {b, acc_ff[31:8]};
               if (pend_ff > 3'd1) begin
                  pend_in = pend_ff - 3'd1;
               end else begin
                  pend_in   = '0;
                  res_valid = 1'b1;
                  phase_in  = PH_OPCODE;
                  if (kind_ff == KIND_LEA) begin
                     res_data = lea_result(mod_ff, rm_ff, sib_ff, reg_ff, acc_in, cnt_in);
                  end else begin
                     res_data.status  = ST_OK;
                     res_data.kind    = KIND_MOVI;
                     res_data.dst_reg = reg_ff;
                     res_data.value   = acc_in;
                     res_data.length  = cnt_in;
                  end
               end
            end
            default: begin
               // new opcode: drop all held fields
               cnt_in  = 3'd1;
               kind_in = KIND_NOP;
               dir_in  = 1'b0;
               mod_in  = '0;
               reg_in  = '0;
               rm_in   = '0;
               sib_in  = '0;
               acc_in  = '0;
               pend_in = '0;
               phase_in = PH_OPCODE;
               if (b == OP_NOP) begin
                  res_valid       = 1'b1;
                  res_data.status = ST_OK;
                  res_data.kind   = KIND_NOP;
                  res_data.length = cnt_in;
               end else if (b >= OP_MOVI_LO && b <= OP_MOVI_HI) begin
                  kind_in  = KIND_MOVI;
                  reg_in   = b[2:0];
                  pend_in  = IMM32_BYTES;
                  phase_in = PH_VALUE;
               end else if (b == OP_MOV_STORE || b == OP_MOV_LOAD) begin
                  kind_in  = KIND_MOVR;
                  dir_in   = (b == OP_MOV_LOAD);
                  phase_in = PH_MODRM;
               end else if (b == OP_LEA) begin
                  kind_in  = KIND_LEA;
                  phase_in = PH_MODRM;
               end else begin
                  res_valid = 1'b1;
                  res_data  = reject_result(cnt_in);
               end
            end
         endcase
      end
   end

   // Hold decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         kind_ff  <= KIND_NOP;
         dir_ff   <= 1'b0;
         mod_ff   <= '0;
         reg_ff   <= '0;
         rm_ff    <= '0;
         sib_ff   <= '0;
         acc_ff   <= '0;
         pend_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         dir_ff   <= dir_in;
         mod_ff   <= mod_in;
         reg_ff   <= reg_in;
         rm_ff    <= rm_in;
         sib_ff   <= sib_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ia32_mov_lea_decoder_unit.sv
// A result reaches rsp through the output register, or first the skid register.
// Throughput: one code byte per cycle while req_stall is low; the per-byte decode
// is a single combinational pass. A result register plus one skid register keep
// req open while rsp is stalled once. Reset (synchronous, active high) empties both result
// registers and returns the decoder to expecting an opcode with all held fields cleared.
`default_nettype none

module ia32_mov_lea_decoder_unit
   import ia32ml_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    beat_accept;
   logic    res_valid;
   rsp_type res_data;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_take;

   assign req_stall   = skid_valid_ff;
   assign beat_accept = req_valid && !req_stall;
   assign out_take    = out_valid_ff && !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_data_ff;

   ia32ml_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   // Steer new results into the output or skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = res_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Advance result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   // skid register fills only behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register valid while output register empty");

   // a result taken while the output is stalled lands in the skid register
   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      res_valid && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("result dropped under output stall");

   // rejections are one or two bytes long
   a_reject_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_REJECT |->
      rsp_data.length == 3'd1 || rsp_data.length == 3'd2)
      else $error("rejection with bad length");

   // mov immediate always spans five bytes
   a_movi_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OK && rsp_data.kind == KIND_MOVI |->
      rsp_data.length == 3'd5)
      else $error("mov immediate with bad length");
`endif

endmodule

`default_nettype wire
